// ===== design/epza_pkg.sv =====
// shared types and constants for the eased pan/zoom animator
// payload structs, register indexes, sequencer states; no dependencies
package epza_pkg;

  localparam int FRACTION_BITS = 16;

  localparam int COORD_W    = 32;
  localparam int ZOOM_W     = 24;
  localparam int STEP_W     = 20;
  localparam int DUR_W      = 20;
  localparam int VP_W       = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_DURATION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VP_HEIGHT = 2'd2;

  localparam logic [DUR_W-1:0] DURATION_RST  = 20'd300000;
  localparam logic [VP_W-1:0]  VP_WIDTH_RST  = 14'd1920;
  localparam logic [VP_W-1:0]  VP_HEIGHT_RST = 14'd1080;

  localparam logic MODE_JUMP = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_T2,
    ST_T3,
    ST_EASE,
    ST_LX,
    ST_LY,
    ST_LZ,
    ST_ZOOM,
    ST_OX,
    ST_OY,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                       mode;
    logic                       waypoint_present;
    logic signed [COORD_W-1:0]  current_center_x;
    logic signed [COORD_W-1:0]  current_center_y;
    logic        [ZOOM_W-1:0]   current_zoom;
    logic signed [COORD_W-1:0]  target_center_x;
    logic signed [COORD_W-1:0]  target_center_y;
    logic        [ZOOM_W-1:0]   target_zoom;
    logic        [STEP_W-1:0]   time_step;
  } in_item_t;

  typedef struct packed {
    logic        [ZOOM_W-1:0]   view_scale;
    logic signed [COORD_W-1:0]  view_offset_x;
    logic signed [COORD_W-1:0]  view_offset_y;
    logic                       still_animating;
    logic                       saturated;
  } out_item_t;

endpackage

// ===== design/eased_pan_zoom_animator.sv =====
// eased pan/zoom animator: restoring divider and one shared multiplier under a sequencer
// depends on epza_pkg for payload structs, register indexes and states
// a jump item is taken straight from idle; a tick item while animating passes through
// idle, FRAC_BITS+1 divider steps for t, nine multiplier/adder steps and a write-out,
// and no new item is taken until the sequencer is back in idle; write-out waits
// while the previous item is still held on out_data
// reset is synchronous, active low: registers return to defaults, no animation running
module eased_pan_zoom_animator
  import epza_pkg::*;
#(
  parameter int FRAC_BITS = FRACTION_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int QW = FRAC_BITS + 1;
  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam int EW = QW + 2;
  localparam int AW = COORD_W + 1;
  localparam int BW = (FRAC_BITS + 2 > ZOOM_W + 1) ? FRAC_BITS + 2 : ZOOM_W + 1;
  localparam int PW = AW + BW;
  localparam int RW = PW + 1;
  localparam logic [QW-1:0] T_ONE = QW'(1) << FRAC_BITS;

  state_t state_r, state_nxt;

  logic [DUR_W-1:0] dur_r;
  logic [VP_W-1:0]  vpw_r;
  logic [VP_W-1:0]  vph_r;

  logic signed [COORD_W-1:0] start_x_r, start_y_r;
  logic        [ZOOM_W-1:0]  start_z_r;
  logic signed [AW-1:0]      dx_r, dy_r;
  logic signed [ZOOM_W:0]    dz_r;
  logic [DUR_W-1:0]          elapsed_r;
  logic                      animating_r;

  logic [DUR_W-1:0] rem_r;
  logic [CW-1:0]    cnt_r;
  logic [QW-1:0]    t_r;
  logic [QW-1:0]    t2_r;
  logic [QW-1:0]    e_r;
  logic signed [COORD_W-1:0] cx_r, cy_r, ox_r;
  logic [ZOOM_W-1:0] zoom_r;
  logic              sat_r;
  logic signed [PW-1:0] prod_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  // control decode
  logic accept;
  logic start_div;
  logic mul_en;
  logic out_free;
  logic div_last;

  // datapath signals
  logic [DUR_W-1:0]   dur_eff;
  logic [DUR_W:0]     step_sum;
  logic [DUR_W-1:0]   elapsed_new;
  logic [DUR_W:0]     trial;
  logic               qbit;
  logic [DUR_W:0]     trial_sub;
  logic [QW-1:0]      prod_q;
  logic [EW-1:0]      e_raw;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_sh;
  logic signed [PW-1:0] lerp_x;
  logic signed [PW-1:0] lerp_z;
  logic [VP_W-1:0]      off_size;
  logic signed [RW-1:0] off_raw;
  logic [RW-COORD_W:0]  off_hi;
  logic                 off_ovf;
  logic signed [COORD_W-1:0] off_val;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r <= DURATION_RST;
      vpw_r <= VP_WIDTH_RST;
      vph_r <= VP_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DURATION:  dur_r <= cfg_wdata[DUR_W-1:0];
        CFG_VP_WIDTH:  vpw_r <= cfg_wdata[VP_W-1:0];
        CFG_VP_HEIGHT: vph_r <= cfg_wdata[VP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start_div) state_nxt = ST_DIV;
      ST_DIV:  if (div_last) state_nxt = ST_T2;
      ST_T2:   state_nxt = ST_T3;
      ST_T3:   state_nxt = ST_EASE;
      ST_EASE: state_nxt = ST_LX;
      ST_LX:   state_nxt = ST_LY;
      ST_LY:   state_nxt = ST_LZ;
      ST_LZ:   state_nxt = ST_ZOOM;
      ST_ZOOM: state_nxt = ST_OX;
      ST_OX:   state_nxt = ST_OY;
      ST_OY:   state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_ready  = 1'b0;
    mul_en    = 1'b0;
    div_last  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_DIV:  div_last = (cnt_r == '0);
      ST_T2, ST_T3, ST_LX, ST_LY, ST_LZ, ST_OX, ST_OY: mul_en = 1'b1;
      default: ;
    endcase
  end

  assign accept    = in_valid && in_ready;
  assign start_div = accept && (in_data.mode == MODE_TICK) && animating_r;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- elapsed time and divider step ----------------
  assign dur_eff     = (dur_r == '0) ? DUR_W'(1) : dur_r;
  assign step_sum    = {1'b0, elapsed_r} + {1'b0, in_data.time_step};
  assign elapsed_new = (step_sum > {1'b0, dur_eff}) ? dur_eff : step_sum[DUR_W-1:0];

  // first step compares elapsed itself, later ones the doubled remainder
  assign trial     = (cnt_r == CW'(FRAC_BITS)) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign qbit      = (trial >= {1'b0, dur_eff});
  assign trial_sub = trial - {1'b0, dur_eff};

  // ---------------- shared multiplier ----------------
  assign prod_q  = prod_r[FRAC_BITS +: QW];
  assign prod_sh = prod_r >>> FRAC_BITS;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_T2: begin
        mul_a = $signed({{(AW-QW){1'b0}}, t_r});
        mul_b = $signed({{(BW-QW){1'b0}}, t_r});
      end
      ST_T3: begin
        mul_a = $signed({{(AW-QW){1'b0}}, prod_q});
        mul_b = $signed({{(BW-QW){1'b0}}, t_r});
      end
      ST_LX: begin
        mul_a = dx_r;
        mul_b = $signed({{(BW-QW){1'b0}}, e_r});
      end
      ST_LY: begin
        mul_a = dy_r;
        mul_b = $signed({{(BW-QW){1'b0}}, e_r});
      end
      ST_LZ: begin
        mul_a = AW'(dz_r);
        mul_b = $signed({{(BW-QW){1'b0}}, e_r});
      end
      ST_OX: begin
        mul_a = AW'(cx_r);
        mul_b = $signed({{(BW-ZOOM_W){1'b0}}, zoom_r});
      end
      ST_OY: begin
        mul_a = AW'(cy_r);
        mul_b = $signed({{(BW-ZOOM_W){1'b0}}, zoom_r});
      end
      default: ;
    endcase
  end

  // ease: 3*t2 - 2*t3, t3 sits in the product register
  assign e_raw = ({2'b00, t2_r} + {1'b0, t2_r, 1'b0}) - {1'b0, prod_q, 1'b0};

  assign lerp_x = PW'(start_x_r) + prod_sh;
  assign lerp_z = PW'($signed({1'b0, start_z_r})) + prod_sh;

  // offset = size * 2^(F-1) - floor(zoom * c / 2^F), clipped to 32 bits
  assign off_size = (state_r == ST_FIN) ? vph_r : vpw_r;
  assign off_raw  = RW'($signed({1'b0, off_size, {(FRAC_BITS-1){1'b0}}})) - RW'(prod_sh);
  assign off_hi   = off_raw[RW-1:COORD_W-1];
  assign off_ovf  = !((&off_hi) || !(|off_hi));

  always_comb begin
    if (!off_ovf) begin
      off_val = off_raw[COORD_W-1:0];
    end else if (off_raw[RW-1]) begin
      off_val = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      off_val = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  // ---------------- animation state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r   <= '0;
      start_y_r   <= '0;
      start_z_r   <= '0;
      dx_r        <= '0;
      dy_r        <= '0;
      dz_r        <= '0;
      elapsed_r   <= '0;
      animating_r <= 1'b0;
    end else begin
      if (accept && (in_data.mode == MODE_JUMP) && in_data.waypoint_present) begin
        start_x_r   <= in_data.current_center_x;
        start_y_r   <= in_data.current_center_y;
        start_z_r   <= in_data.current_zoom;
        dx_r        <= AW'($signed(in_data.target_center_x))
                     - AW'($signed(in_data.current_center_x));
        dy_r        <= AW'($signed(in_data.target_center_y))
                     - AW'($signed(in_data.current_center_y));
        dz_r        <= $signed({1'b0, in_data.target_zoom})
                     - $signed({1'b0, in_data.current_zoom});
        elapsed_r   <= '0;
        animating_r <= 1'b1;
      end else if (start_div) begin
        elapsed_r <= elapsed_new;
      end
      // final frame ends the animation
      if (state_r == ST_FIN && out_free && t_r[FRAC_BITS]) begin
        animating_r <= 1'b0;
      end
    end
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk) begin
    if (start_div) begin
      rem_r <= elapsed_new;
      cnt_r <= CW'(FRAC_BITS);
    end else if (state_r == ST_DIV) begin
      rem_r <= qbit ? trial_sub[DUR_W-1:0] : trial[DUR_W-1:0];
      t_r   <= {t_r[QW-2:0], qbit};
      cnt_r <= cnt_r - CW'(1);
    end
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (state_r)
      ST_T3:   t2_r   <= prod_q;
      ST_EASE: e_r    <= (e_raw > {2'b00, T_ONE}) ? T_ONE : e_raw[QW-1:0];
      ST_LY:   cx_r   <= lerp_x[COORD_W-1:0];
      ST_LZ:   cy_r   <= lerp_x[COORD_W-1:0] - start_x_r + start_y_r;
      ST_ZOOM: zoom_r <= lerp_z[ZOOM_W-1:0];
      ST_OY: begin
        ox_r  <= off_val;
        sat_r <= off_ovf;
      end
      default: ;
    endcase
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_data_r.view_scale      <= zoom_r;
      out_data_r.view_offset_x   <= ox_r;
      out_data_r.view_offset_y   <= off_val;
      out_data_r.still_animating <= !t_r[FRAC_BITS];
      out_data_r.saturated       <= sat_r || off_ovf;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== test/tb_eased_pan_zoom_animator.sv =====
// self-checking testbench for the eased pan/zoom animator
// drives jump and tick items, predicts each view frame and compares it field by field
// depends on epza_pkg and design/eased_pan_zoom_animator.sv
module tb_eased_pan_zoom_animator;
  timeunit 1ns;
  timeprecision 1ps;

  import epza_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint unsigned ONE_Q = 64'd1 << FRACTION_BITS;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam int SETTLE_CYCLES = FRACTION_BITS + 24;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 165;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // mirror of the block's registers and animation state
  logic [DUR_W-1:0] dur_cfg = DURATION_RST;
  logic [VP_W-1:0] vp_w_cfg = VP_WIDTH_RST;
  logic [VP_W-1:0] vp_h_cfg = VP_HEIGHT_RST;
  longint from_x = 0, from_y = 0, from_zoom = 0;
  longint to_x = 0, to_y = 0, to_zoom = 0;
  longint unsigned elapsed = 0;
  bit running = 1'b0;

  out_item_t pending_frames[$];
  out_item_t due_frame;
  int mismatches = 0;
  int worked_items = 0;
  int quiet_cycles = 0;
  int gap_max = 4;
  int stall_max = 4;

  eased_pan_zoom_animator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint blend(input longint a, input longint b, input longint unsigned e);
    return a + (((b - a) * longint'(e)) >>> FRACTION_BITS);
  endfunction

  // viewport middle minus zoom times center, clipped to the coordinate range
  function automatic logic signed [COORD_W-1:0] place_offset(input longint unsigned size,
      input longint unsigned zoom, input longint c, inout bit clipped);
    longint half, r;
    half = longint'((size << FRACTION_BITS) >> 1);
    r = half - ((longint'(zoom) * c) >>> FRACTION_BITS);
    if (r > COORD_MAX) begin
      clipped = 1'b1;
      r = COORD_MAX;
    end else if (r < COORD_MIN) begin
      clipped = 1'b1;
      r = COORD_MIN;
    end
    return r[COORD_W-1:0];
  endfunction

  // updates the mirrored state for one item; returns 1 when a frame is due
  function automatic bit advance_view(input in_item_t item, output out_item_t frame);
    longint unsigned span, t, t2, t3, ease, scale;
    longint cx, cy;
    bit clipped;
    frame = '0;
    clipped = 1'b0;
    if (item.mode == MODE_JUMP) begin
      if (item.waypoint_present) begin
        from_x = $signed(item.current_center_x);
        from_y = $signed(item.current_center_y);
        from_zoom = item.current_zoom;
        to_x = $signed(item.target_center_x);
        to_y = $signed(item.target_center_y);
        to_zoom = item.target_zoom;
        elapsed = 0;
        running = 1'b1;
      end
      return 1'b0;
    end
    if (!running) return 1'b0;
    span = (dur_cfg == 0) ? 64'd1 : dur_cfg;
    elapsed = elapsed + item.time_step;
    if (elapsed > span) elapsed = span;
    t = (elapsed << FRACTION_BITS) / span;
    if (t > ONE_Q) t = ONE_Q;
    t2 = (t * t) >> FRACTION_BITS;
    t3 = (t2 * t) >> FRACTION_BITS;
    ease = 3 * t2 - 2 * t3;
    if (ease > ONE_Q) ease = ONE_Q;
    cx = blend(from_x, to_x, ease);
    cy = blend(from_y, to_y, ease);
    // lies between the two zooms, so it fits the field
    scale = longint'(blend(from_zoom, to_zoom, ease)) & 64'hFF_FFFF;
    if (t >= ONE_Q) running = 1'b0;
    frame.view_scale = scale[ZOOM_W-1:0];
    frame.view_offset_x = place_offset(vp_w_cfg, scale, cx, clipped);
    frame.view_offset_y = place_offset(vp_h_cfg, scale, cy, clipped);
    frame.still_animating = running;
    frame.saturated = clipped;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint wnt);
    mismatches++;
    if (mismatches <= 40) $display("mismatch %s: got %0d, expected %0d", what, got, wnt);
  endtask

  task automatic send_item(input in_item_t item);
    int gap;
    bit has_frame, worked;
    out_item_t frame;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    worked = (item.mode == MODE_TICK) ? running : item.waypoint_present;
    has_frame = advance_view(item, frame);
    if (has_frame) pending_frames.push_back(frame);
    if (worked) worked_items++;
  endtask

  // sender holds off until every frame is out and the block has gone quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DURATION:  dur_cfg = value;
      CFG_VP_WIDTH:  vp_w_cfg = value[VP_W-1:0];
      CFG_VP_HEIGHT: vp_h_cfg = value[VP_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return r;
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  function automatic logic [ZOOM_W-1:0] rand_zoom();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return r[ZOOM_W-1:0];
      default: return 24'h0_8000 + r[16:0];
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t item;
    item.mode = 1'($urandom);
    item.waypoint_present = 1'($urandom);
    item.current_center_x = rand_coord();
    item.current_center_y = rand_coord();
    item.current_zoom = rand_zoom();
    item.target_center_x = rand_coord();
    item.target_center_y = rand_coord();
    item.target_zoom = rand_zoom();
    item.time_step = STEP_W'($urandom);
    return item;
  endfunction

  function automatic in_item_t make_jump();
    in_item_t item;
    item = rand_item();
    item.mode = MODE_JUMP;
    item.waypoint_present = 1'b1;
    return item;
  endfunction

  task automatic send_tick(input logic [STEP_W-1:0] step);
    in_item_t item;
    item = rand_item();
    item.mode = MODE_TICK;
    item.time_step = step;
    send_item(item);
  endtask

  task automatic send_jump(input logic [31:0] x0, input logic [31:0] y0,
      input logic [ZOOM_W-1:0] z0, input logic [31:0] x1, input logic [31:0] y1,
      input logic [ZOOM_W-1:0] z1);
    in_item_t item;
    item = make_jump();
    item.current_center_x = x0;
    item.current_center_y = y0;
    item.current_zoom = z0;
    item.target_center_x = x1;
    item.target_center_y = y1;
    item.target_zoom = z1;
    send_item(item);
  endtask

  // one jump followed by ticks sized to finish in a handful of frames
  task automatic run_flight();
    int planned, ticks;
    int unsigned span, reach;
    send_item(make_jump());
    span = (dur_cfg == 0) ? 1 : dur_cfg;
    planned = $urandom_range(1, 12);
    reach = (2 * span) / planned + 1;
    if (reach > 20'hFFFFF) reach = 20'hFFFFF;
    ticks = 0;
    while (running) begin
      ticks++;
      case ($urandom_range(0, 19))
        0: send_tick(STEP_W'($urandom));
        1: if (ticks > 2) return;
        2: settle_block();
        default: send_tick((ticks > 30) ? 20'hFFFFF : STEP_W'($urandom_range(0, reach)));
      endcase
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_duration();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 1;
      2: return '1;
      3: return CFG_DATA_W'($urandom_range(1, 64));
      4, 5: return CFG_DATA_W'($urandom_range(1000, 400000));
      6: return CFG_DATA_W'($urandom);
      default: return DURATION_RST;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_viewport();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 1;
      2: return 8192;
      3: return '1;
      4: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1, 8192));
    endcase
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 14;
      default: return $urandom_range(1, 13);
    endcase
  endfunction

  task automatic test_ignored_items();
    in_item_t item;
    send_tick(1000);
    item = make_jump();
    item.waypoint_present = 1'b0;
    send_item(item);
    send_tick(20'hFFFFF);
  endtask

  task automatic test_field_extremes();
    send_jump(32'h8000_0000, 32'h7FFF_FFFF, 24'h0, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
    send_tick(0);
    send_tick(150000);
    send_tick(20'hFFFFF);   // overrun clamps elapsed to the duration
    send_tick(5);
    send_jump(32'h0, 32'h0, 24'h1_0000, 32'hFFFF_0000, 32'h0001_0000, 24'h0_8000);
    send_tick(100000);
    // restart while still animating
    send_jump(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_tick(1);
    send_tick(299998);
    send_tick(1);           // lands exactly on the duration
    send_tick(0);
  endtask

  task automatic test_register_writes();
    settle_block();
    write_reg(CFG_DURATION, '0);        // zero acts as one microsecond
    write_reg(CFG_UNUSED, 20'hABCDE);
    write_reg(CFG_VP_WIDTH, '1);        // upper bits dropped
    write_reg(CFG_VP_HEIGHT, '0);
    send_item(make_jump());
    send_tick(0);
    send_tick(1);
    settle_block();
    write_reg(CFG_DURATION, '1);
    write_reg(CFG_VP_WIDTH, 8192);
    write_reg(CFG_VP_HEIGHT, 1);
    send_item(make_jump());
    send_tick(20'hFFFFE);
    send_tick(20'hFFFFF);
    settle_block();
    write_reg(CFG_DURATION, 1);
    write_reg(CFG_VP_WIDTH, 1);
    write_reg(CFG_VP_HEIGHT, 8192);
    send_item(make_jump());
    send_tick(0);
    send_tick(20'hFFFFF);
  endtask

  task automatic test_random_animations();
    int quota;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_block();
      write_reg(CFG_DURATION, pick_duration());
      write_reg(CFG_VP_WIDTH, pick_viewport());
      write_reg(CFG_VP_HEIGHT, pick_viewport());
      gap_max = (phase == 0) ? 0 : (phase == 1) ? 14 : pick_idle();
      stall_max = (phase == 0) ? 0 : (phase == 1) ? 14 : pick_idle();
      quota = worked_items + PHASE_ITEMS;
      while (worked_items < quota) begin
        if ($urandom_range(0, 9) == 0) send_item(rand_item());
        else run_flight();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ignored_items();
    test_field_extremes();
    test_register_writes();
    test_random_animations();
    settle_block();
    if (mismatches == 0) begin
      $display("eased_pan_zoom_animator test passed");
    end else begin
      $display("eased_pan_zoom_animator test failed");
    end
    $finish;
  end

  initial begin : frame_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready === 1'b1));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("frame with none expected, view_scale", out_data.view_scale, 0);
      end else begin
        due_frame = pending_frames.pop_front();
        if (out_data.view_scale !== due_frame.view_scale)
          report_mismatch("view_scale", out_data.view_scale, due_frame.view_scale);
        if (out_data.view_offset_x !== due_frame.view_offset_x)
          report_mismatch("view_offset_x", out_data.view_offset_x, due_frame.view_offset_x);
        if (out_data.view_offset_y !== due_frame.view_offset_y)
          report_mismatch("view_offset_y", out_data.view_offset_y, due_frame.view_offset_y);
        if (out_data.still_animating !== due_frame.still_animating)
          report_mismatch("still_animating", out_data.still_animating,
                          due_frame.still_animating);
        if (out_data.saturated !== due_frame.saturated)
          report_mismatch("saturated", out_data.saturated, due_frame.saturated);
      end
    end
  end

  // counts cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("eased_pan_zoom_animator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
